@@ rtl/firl_pkg.sv @@
// shared constants, command codes and status types of the long fir filter
package firl_pkg;

  localparam int MAX_TAPS_DEF    = 2048;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int COEF_INDEX_W = 11;
  localparam int OPCODE_W     = 2;
  localparam int CFG_W        = 12;
  localparam logic [CFG_W-1:0] TAP_COUNT_RESET = 12'd2000;

  localparam int CMD_DEPTH = 4;

  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_SAMPLE,
    CMD_CLEAR
  } cmd_kind_t;

  localparam int KIND_W = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic busy;
    logic finishing;
  } back_stat_t;

endpackage

@@ rtl/firl_front.sv @@
// input side: accepts items, drops ignored ones and packs commands for the queue
module firl_front import firl_pkg::*; #(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IDX_W      = $clog2(MAX_TAPS),
  localparam int CMD_W      = KIND_W + IDX_W + SAMPLE_BITS
) (
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [OPCODE_W-1:0]    in_opcode,
  input  logic [COEF_INDEX_W-1:0] in_coef_index,
  input  logic [SAMPLE_BITS-1:0] in_value,
  input  fifo_stat_t             fifo_stat,
  output logic                   cmd_push,
  output logic [CMD_W-1:0]       cmd_data
);

  localparam int IW = ((COEF_INDEX_W > IDX_W) ? COEF_INDEX_W : IDX_W) + 1;

  logic          accept;
  logic          keep;
  logic          in_range;
  logic [IW-1:0] idx_ext;
  cmd_kind_t     kind;

  assign accept   = in_push && !fifo_stat.full;
  assign idx_ext  = IW'(in_coef_index);
  assign in_range = idx_ext < IW'(MAX_TAPS);

  always_comb begin
    keep = 1'b0;
    kind = CMD_LOAD;
    unique case (in_opcode)
      OP_LOAD: begin
        // loads beyond the store are dropped here
        keep = in_range;
        kind = CMD_LOAD;
      end
      OP_SAMPLE: begin
        keep = 1'b1;
        kind = CMD_SAMPLE;
      end
      OP_CLEAR: begin
        keep = 1'b1;
        kind = CMD_CLEAR;
      end
      default: begin
        keep = 1'b0;
        kind = CMD_LOAD;
      end
    endcase
  end

  assign in_full  = fifo_stat.full;
  assign cmd_push = accept && keep;
  assign cmd_data = {kind, idx_ext[IDX_W-1:0], in_value};

endmodule

@@ rtl/firl_cmd_fifo.sv @@
// short command queue between the input side and the filter engine
module firl_cmd_fifo import firl_pkg::*; #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output fifo_stat_t       stat
);

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] entry_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = count_r == CNT_W'(CMD_DEPTH);
  assign stat.empty = count_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/firl_back.sv @@
// filter engine: coefficient and history memories, mac pipeline, rounding, result register
module firl_back import firl_pkg::*; #(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IDX_W      = $clog2(MAX_TAPS),
  localparam int CMD_W      = KIND_W + IDX_W + SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CFG_W-1:0]       tap_count,
  input  logic [CMD_W-1:0]       cmd_data,
  input  fifo_stat_t             fifo_stat,
  output logic                   cmd_pop,
  input  logic                   out_pop,
  output logic                   out_empty,
  output logic [SAMPLE_BITS-1:0] out_filtered,
  output back_stat_t             back_stat
);

  localparam int CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int CMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int ACC_RAW = PROD_W + IDX_W + 2;
  localparam int ACC_W   = (ACC_RAW > 64) ? 64 : ACC_RAW;
  localparam int FRAC    = SAMPLE_BITS - 1;

  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< FRAC) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];

  back_state_t state_r, state_nxt;

  cmd_kind_t                     cmd_kind;
  logic [IDX_W-1:0]              cmd_addr;
  logic signed [SAMPLE_BITS-1:0] cmd_val;

  logic [IDX_W-1:0] ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic [IDX_W-1:0] j_r;
  logic [IDX_W-1:0] slot_r;
  logic [CNT_W-1:0] left_r;
  logic             rd_v_r;
  logic             mul_v_r;

  logic signed [SAMPLE_BITS-1:0] coef_q_r;
  logic signed [SAMPLE_BITS-1:0] hist_q_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_filtered_r;

  logic [CNT_W-1:0] taps_sat;
  logic [CNT_W-1:0] fill_inc;
  logic [CNT_W-1:0] n_first;
  logic [IDX_W-1:0] ptr_inc;
  logic [IDX_W-1:0] slot_dec;
  logic             slot_free;
  logic             do_load;
  logic             do_sample;
  logic             do_clear;
  logic             rd_en;
  logic             res_load;

  logic signed [ACC_W-1:0] biased;
  logic signed [ACC_W-1:0] shifted;
  logic signed [ACC_W-1:0] sat;

  assign cmd_kind = cmd_kind_t'(cmd_data[CMD_W-1 -: KIND_W]);
  assign cmd_addr = cmd_data[SAMPLE_BITS +: IDX_W];
  assign cmd_val  = cmd_data[SAMPLE_BITS-1:0];

  always_comb begin
    if (CMP_W'(tap_count) > CMP_W'(MAX_TAPS)) begin
      taps_sat = CNT_W'(MAX_TAPS);
    end else begin
      taps_sat = CNT_W'(tap_count);
    end
  end

  // taps older than the last clear only add zero, so the walk stops at the fill
  assign fill_inc  = (fill_r == CNT_W'(MAX_TAPS)) ? fill_r : fill_r + CNT_W'(1);
  assign n_first   = (taps_sat < fill_inc) ? taps_sat : fill_inc;
  assign ptr_inc   = (ptr_r == IDX_W'(MAX_TAPS - 1)) ? '0 : ptr_r + IDX_W'(1);
  assign slot_dec  = (slot_r == '0) ? IDX_W'(MAX_TAPS - 1) : slot_r - IDX_W'(1);
  assign slot_free = !out_valid_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_stat.empty && cmd_kind == CMD_SAMPLE) begin
          state_nxt = (n_first == '0) ? ST_ROUND : ST_MAC;
        end
      end
      ST_MAC: begin
        if (left_r == CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !mul_v_r) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd_pop   = (state_r == ST_IDLE) && !fifo_stat.empty;
    do_load   = cmd_pop && cmd_kind == CMD_LOAD;
    do_sample = cmd_pop && cmd_kind == CMD_SAMPLE;
    do_clear  = cmd_pop && cmd_kind == CMD_CLEAR;
    rd_en     = state_r == ST_MAC;
    res_load  = (state_r == ST_ROUND) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      fill_r      <= '0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_en;
      mul_v_r <= rd_v_r;
      if (do_clear) begin
        ptr_r  <= '0;
        fill_r <= '0;
      end else if (do_sample) begin
        ptr_r  <= ptr_inc;
        fill_r <= fill_inc;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      coef_mem[cmd_addr] <= cmd_val;
    end
    if (rd_en) begin
      coef_q_r <= coef_mem[j_r];
    end
  end

  always_ff @(posedge clk) begin
    if (do_sample) begin
      hist_mem[ptr_r] <= cmd_val;
    end
    if (rd_en) begin
      hist_q_r <= hist_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (do_sample) begin
      j_r    <= '0;
      slot_r <= ptr_r;
      left_r <= n_first;
    end else if (rd_en) begin
      j_r    <= j_r + IDX_W'(1);
      slot_r <= slot_dec;
      left_r <= left_r - CNT_W'(1);
    end
    if (rd_v_r) begin
      prod_r <= coef_q_r * hist_q_r;
    end
    if (do_sample) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then clamp to the sample range
  always_comb begin
    biased  = acc_r + RND;
    shifted = biased >>> FRAC;
    if (shifted > SAT_HI) begin
      sat = SAT_HI;
    end else if (shifted < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_filtered_r <= sat[SAMPLE_BITS-1:0];
    end
  end

  assign out_empty           = !out_valid_r;
  assign out_filtered        = out_filtered_r;
  assign back_stat.busy      = state_r != ST_IDLE;
  assign back_stat.finishing = res_load;

endmodule

@@ rtl/fir_filter_long.sv @@
// long direct-form fir filter: top level with tap count register
// a sample passes the command queue; the engine then walks n = min(tap_count,
//   samples since reset or clear, this one included) taps, one tap a cycle
//   through the single multiply-accumulate, and rounds into the result register
//   once it is free; later items wait in the queue; loads and clears walk no taps
// reset: synchronous active low; history reads as zero via a fill count; tap_count 2000
module fir_filter_long import firl_pkg::*; #(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [OPCODE_W-1:0]     in_opcode,
  input  logic [COEF_INDEX_W-1:0] in_coef_index,
  input  logic [SAMPLE_BITS-1:0]  in_value,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [SAMPLE_BITS-1:0]  out_filtered,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int IDX_W = $clog2(MAX_TAPS);
  localparam int CMD_W = KIND_W + IDX_W + SAMPLE_BITS;

  logic [CFG_W-1:0] tap_count_r;
  fifo_stat_t       fifo_stat;
  back_stat_t       back_stat;
  logic             cmd_push;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_in_data;
  logic [CMD_W-1:0] cmd_out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tap_count_r <= cfg_data;
    end
  end

  firl_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_coef_index (in_coef_index),
    .in_value      (in_value),
    .fifo_stat     (fifo_stat),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in_data)
  );

  firl_cmd_fifo #(
    .WIDTH (CMD_W)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in_data),
    .pop       (cmd_pop),
    .pop_data  (cmd_out_data),
    .stat      (fifo_stat)
  );

  firl_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .tap_count    (tap_count_r),
    .cmd_data     (cmd_out_data),
    .fifo_stat    (fifo_stat),
    .cmd_pop      (cmd_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_filtered (out_filtered),
    .back_stat    (back_stat)
  );

`ifndef SYNTHESIS
  // a result shows up only when the engine finishes rounding
  a_result_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(back_stat.finishing))
    else $error("result appeared without a finished sample");

  // the engine starts work only on a command it took from the queue
  a_busy_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(back_stat.busy) |-> $past(cmd_pop))
    else $error("engine started without a command transfer");

  // queued commands stay until the engine takes them
  a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fifo_stat.empty && !cmd_pop |=> !fifo_stat.empty)
    else $error("command queue lost an entry");
`endif

endmodule

@@ test/tb_fir_filter_long.sv @@
// self-checking testbench for the long fir filter: directed table, then random phases
module tb_fir_filter_long;
  import firl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS_MAX = MAX_TAPS_DEF;
  localparam int VAL_W    = SAMPLE_BITS_DEF;
  localparam int GAP_MAX  = 18;
  // wait long enough for the longest sample and any trailing loads or clears to finish
  localparam int SETTLE_CYCLES  = 2100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DIRECTED_ROWS  = 24;
  localparam int PHASES         = 12;
  localparam int LOADED_TAPS    = 48;
  localparam int PHASE_ITEMS    = 18;

  localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;

  localparam logic signed [63:0] OUT_HI = 64'sd32767;
  localparam logic signed [63:0] OUT_LO = -64'sd32768;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_W-1:0]        taps;
    logic [OPCODE_W-1:0]     op;
    logic [COEF_INDEX_W-1:0] idx;
    logic [VAL_W-1:0]        val;
    logic                    has_want;
    logic [VAL_W-1:0]        want;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_push;
  logic                    in_full;
  logic [OPCODE_W-1:0]     in_opcode;
  logic [COEF_INDEX_W-1:0] in_coef_index;
  logic [VAL_W-1:0]        in_value;
  logic                    out_empty;
  logic                    out_pop;
  logic [VAL_W-1:0]        out_filtered;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        cfg_data;

  // typed expectation that rides along with the item being driven
  logic                    cur_has_want;
  logic [VAL_W-1:0]        cur_want;

  // filter state as the block should hold it
  logic signed [VAL_W-1:0] coef_mem [TAPS_MAX];
  logic signed [VAL_W-1:0] hist_mem [TAPS_MAX];
  logic [COEF_INDEX_W-1:0] hist_ptr = '0;
  logic [CFG_W-1:0]        taps_setting = TAP_COUNT_RESET;

  logic [VAL_W-1:0] expected_filtered [$];
  int mismatches   = 0;
  int in_xfers     = 0;
  int out_xfers    = 0;
  int cfg_xfers    = 0;
  int quiet_cycles = 0;
  int in_run       = 0;
  int out_run      = 0;

  stim_row_t directed [DIRECTED_ROWS] = '{
    '{ROW_CFG,  12'd1, OP_LOAD,    11'd0,     16'h0000, 1'b0, 16'h0000},
    '{ROW_ITEM, 12'd0, OP_LOAD,    11'd0,     16'h7fff, 1'b0, 16'h0000},
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'd0,     16'h7fff, 1'b1, 16'h7ffe},
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'd0,     16'h0001, 1'b1, 16'h0001},
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'd0,     16'hffff, 1'b1, 16'hffff},
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'd0,     16'h8000, 1'b1, 16'h8001},
    '{ROW_ITEM, 12'd0, OP_LOAD,    11'd0,     16'h8000, 1'b0, 16'h0000},
    // minus one squared saturates
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'd0,     16'h8000, 1'b1, 16'h7fff},
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'd0,     16'h7fff, 1'b1, 16'h8001},
    '{ROW_ITEM, 12'd0, OP_LOAD,    11'd0,     16'h4000, 1'b0, 16'h0000},
    // exact halves round up
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'd0,     16'h0001, 1'b1, 16'h0001},
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'd0,     16'hffff, 1'b1, 16'h0000},
    '{ROW_ITEM, 12'd0, OP_IGNORED, 11'h7ff,   16'hffff, 1'b0, 16'h0000},
    '{ROW_ITEM, 12'd0, OP_LOAD,    11'h7ff,   16'h1234, 1'b0, 16'h0000},
    '{ROW_ITEM, 12'd0, OP_LOAD,    11'd1,     16'h7fff, 1'b0, 16'h0000},
    '{ROW_ITEM, 12'd0, OP_LOAD,    11'd2,     16'h8000, 1'b0, 16'h0000},
    '{ROW_CFG,  12'd3, OP_LOAD,    11'd0,     16'h0000, 1'b0, 16'h0000},
    '{ROW_ITEM, 12'd0, OP_CLEAR,   11'h7ff,   16'hffff, 1'b0, 16'h0000},
    // older taps see the cleared history
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'd0,     16'h7fff, 1'b1, 16'h4000},
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'd0,     16'h0000, 1'b0, 16'h0000},
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'h555,   16'h1000, 1'b0, 16'h0000},
    '{ROW_CFG,  12'd0, OP_LOAD,    11'd0,     16'h0000, 1'b0, 16'h0000},
    '{ROW_ITEM, 12'd0, OP_SAMPLE,  11'd0,     16'h7fff, 1'b1, 16'h0000},
    '{ROW_ITEM, 12'd0, OP_CLEAR,   11'h2aa,   16'h5555, 1'b0, 16'h0000}
  };

  // every tap count stays within the loaded coefficients
  int phase_taps [PHASES] = '{5, 48, 1, 12, 47, 2, 7, 33, 16, 40, 3, 9};

  fir_filter_long dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_opcode    (in_opcode),
    .in_coef_index(in_coef_index),
    .in_value     (in_value),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_filtered (out_filtered),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // one filter step on the shadow state
  task automatic compute_filter_output(input logic [OPCODE_W-1:0] op,
                                       input logic [COEF_INDEX_W-1:0] idx,
                                       input logic signed [VAL_W-1:0] val,
                                       output logic produced,
                                       output logic [VAL_W-1:0] y);
    int eff;
    logic [COEF_INDEX_W-1:0] slot;
    logic signed [63:0] acc;
    produced = 1'b0;
    y = '0;
    if (op == OP_LOAD) begin
      coef_mem[idx] = val;
    end else if (op == OP_CLEAR) begin
      foreach (hist_mem[k]) hist_mem[k] = '0;
      hist_ptr = '0;
    end else if (op == OP_SAMPLE) begin
      eff = (taps_setting > TAPS_MAX) ? TAPS_MAX : int'(taps_setting);
      hist_mem[hist_ptr] = val;
      acc = '0;
      for (int j = 0; j < eff; j++) begin
        slot = hist_ptr - j[COEF_INDEX_W-1:0];
        acc += 64'(coef_mem[j]) * 64'(hist_mem[slot]);
      end
      hist_ptr = hist_ptr + COEF_INDEX_W'(1);
      acc = (acc + 64'sd16384) >>> (VAL_W - 1);
      if (acc > OUT_HI) acc = OUT_HI;
      if (acc < OUT_LO) acc = OUT_LO;
      y = acc[VAL_W-1:0];
      produced = 1'b1;
    end
  endtask

  // idle length per transfer, with occasional runs of back-to-back transfers
  function automatic int pick_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) run_left = $urandom_range(5, 30);
    return $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    logic produced;
    logic [VAL_W-1:0] y;
    logic busy;
    busy = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        taps_setting = cfg_data;
        cfg_xfers++;
        busy = 1'b1;
      end
      if (out_pop && !out_empty) begin
        if (expected_filtered.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_filtered));
        end else begin
          y = expected_filtered.pop_front();
          if (out_filtered !== y)
            report_mismatch($sformatf("filtered got %h expected %h", out_filtered, y));
        end
        out_xfers++;
        busy = 1'b1;
      end
      if (in_push && !in_full) begin
        compute_filter_output(in_opcode, in_coef_index, in_value, produced, y);
        if (produced) expected_filtered.push_back(cur_has_want ? cur_want : y);
        in_xfers++;
        busy = 1'b1;
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** fir_filter_long: FAILED **");
        $finish;
      end
    end
  end

  // result side: random stall before each pop transfer
  initial begin : result_drain
    int gap;
    int seen;
    out_pop = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      gap = pick_gap(out_run);
      if (gap > 0) begin
        out_pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop = 1'b1;
      seen = out_xfers;
      do @(negedge clk); while (out_xfers == seen);
    end
  end

  task automatic send_item(input logic [OPCODE_W-1:0] op,
                           input logic [COEF_INDEX_W-1:0] idx,
                           input logic [VAL_W-1:0] val,
                           input logic has_want,
                           input logic [VAL_W-1:0] want);
    int gap;
    int seen;
    gap = pick_gap(in_run);
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode     = op;
    in_coef_index = idx;
    in_value      = val;
    cur_has_want  = has_want;
    cur_want      = want;
    in_push       = 1'b1;
    seen = in_xfers;
    do @(negedge clk); while (in_xfers == seen);
  endtask

  // only while idle: all results back and trailing loads or clears done
  task automatic write_tap_count(input logic [CFG_W-1:0] taps);
    int seen;
    in_push = 1'b0;
    while (expected_filtered.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data  = taps;
    cfg_valid = 1'b1;
    seen = cfg_xfers;
    do @(negedge clk); while (cfg_xfers == seen);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_item();
    logic [OPCODE_W-1:0] op;
    int r;
    r = $urandom_range(0, 99);
    if (r < 68)      op = OP_SAMPLE;
    else if (r < 86) op = OP_LOAD;
    else if (r < 94) op = OP_CLEAR;
    else             op = OP_IGNORED;
    send_item(op, COEF_INDEX_W'($urandom), pick_value(), 1'b0, '0);
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_opcode     = OP_LOAD;
    in_coef_index = '0;
    in_value      = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    cur_has_want  = 1'b0;
    cur_want      = '0;
    foreach (coef_mem[k]) coef_mem[k] = '0;
    foreach (hist_mem[k]) hist_mem[k] = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[r]) begin
      if (directed[r].kind == ROW_CFG)
        write_tap_count(directed[r].taps);
      else
        send_item(directed[r].op, directed[r].idx, directed[r].val,
                  directed[r].has_want, directed[r].want);
    end

    // the coefficients that any later tap count reaches get written first
    for (int k = 0; k < LOADED_TAPS; k++)
      send_item(OP_LOAD, COEF_INDEX_W'(k), pick_value(), 1'b0, '0);

    foreach (phase_taps[p]) begin
      write_tap_count(CFG_W'(phase_taps[p]));
      repeat (PHASE_ITEMS) send_random_item();
    end

    in_push = 1'b0;
    while (expected_filtered.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("** fir_filter_long: PASSED **");
    else
      $display("** fir_filter_long: FAILED **");
    $finish;
  end

endmodule
